// ===== design/fsl_pkg.sv =====
// shared types, codes and constants of the fixed-slot free list
package fsl_pkg;

	// default pool capacity and the slot index width of the ports
	localparam int SLOT_COUNT_MAX_DEF = 256;
	localparam int SLOT_IDX_W         = 8;
	localparam int CFG_W              = 9;

	// slot count after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	// operation codes
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// command word fields
	typedef struct packed {
		logic [1:0]            opcode;
		logic [SLOT_IDX_W-1:0] release_slot;
	} cmd_t;

	// result word with its load strobe
	typedef struct packed {
		logic                  load;
		logic [1:0]            status;
		logic [SLOT_IDX_W-1:0] granted_slot;
		logic                  list_empty;
	} rsp_t;

	// link memory access strobes
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

endpackage

// ===== design/fsl_cmd_if.sv =====
// command channel: operation and released slot
interface fsl_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     opcode;
	logic [fsl_pkg::SLOT_IDX_W-1:0] release_slot;

	modport source (output valid, output opcode, output release_slot, input ready);
	modport sink   (input valid, input opcode, input release_slot, output ready);
endinterface

// ===== design/fsl_rsp_if.sv =====
// result channel: status, granted slot and empty flag
interface fsl_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [fsl_pkg::SLOT_IDX_W-1:0] granted_slot;
	logic                           list_empty;

	modport source (output valid, output status, output granted_slot, output list_empty,
		input ready);
	modport sink   (input valid, input status, input granted_slot, input list_empty,
		output ready);
endinterface

// ===== design/fsl_link_mem.sv =====
// link memory: one write port, one read port with registered read data
module fsl_link_mem #(
	parameter int DEPTH  = 256,
	parameter int LINK_W = 9
) (
	input  logic                     clk,
	input  fsl_pkg::mem_cmd_t        cmd,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [LINK_W-1:0]        wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [LINK_W-1:0]        rd_data
);

	logic [LINK_W-1:0] mem_q [DEPTH];
	logic [LINK_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/fsl_ctrl.sv =====
// sequencer: head pointer, pool size, relink sweep and link reads and writes
module fsl_ctrl #(
	parameter int SLOT_COUNT_MAX = fsl_pkg::SLOT_COUNT_MAX_DEF,
	parameter int DEPTH          = 256,
	parameter int LINK_W         = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fsl_pkg::CFG_W-1:0]  slots_cfg,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  fsl_pkg::cmd_t              cmd_word,
	input  logic                       rsp_free,
	output fsl_pkg::rsp_t              rsp_word,
	output fsl_pkg::mem_cmd_t          mem_cmd,
	output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
	output logic [LINK_W-1:0]          mem_wr_data,
	output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
	input  logic [LINK_W-1:0]          mem_rd_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOT_COUNT_MAX);
	localparam logic [CNT_W-1:0]  ACTIVE_MAX = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ALLOC = 3'b010,
		S_SWEEP = 3'b100
	} state_t;

	state_t                         state_q;
	logic [LINK_W-1:0]              head_q;
	logic [CNT_W-1:0]               active_q;
	logic [CNT_W-1:0]               sweep_cnt_q;
	logic                           sweep_rsp_q;
	logic [fsl_pkg::SLOT_IDX_W-1:0] granted_q;

	logic             accept;
	logic             head_empty;
	logic             slot_in_range;
	logic             link_end;
	logic [CNT_W-1:0] sweep_inc;
	logic [CNT_W-1:0] active_clamped;

	// clamp the configured slot count to the pool
	always_comb begin
		if (slots_cfg == '0) begin
			active_clamped = CNT_W'(1);
		end else if (slots_cfg > fsl_pkg::CFG_W'(DEPTH)) begin
			active_clamped = ACTIVE_MAX;
		end else begin
			active_clamped = CNT_W'(slots_cfg);
		end
	end

	// status of the current head and incoming slot
	assign head_empty    = head_q >= LINK_W'(active_q);
	assign slot_in_range = fsl_pkg::CFG_W'(cmd_word.release_slot) < fsl_pkg::CFG_W'(active_q);
	assign link_end      = mem_rd_data >= LINK_W'(active_q);
	assign sweep_inc     = sweep_cnt_q + CNT_W'(1);

	assign cmd_ready = (state_q == S_IDLE) && rsp_free;
	assign accept    = cmd_valid && cmd_ready;

	// memory access and result word
	always_comb begin
		mem_cmd     = '0;
		mem_wr_addr = cmd_word.release_slot[IDX_W-1:0];
		mem_wr_data = head_q;
		mem_rd_addr = head_q[IDX_W-1:0];
		rsp_word    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_word.opcode)
						fsl_pkg::OP_ALLOC: begin
							if (head_empty) begin
								rsp_word.load       = 1'b1;
								rsp_word.status     = fsl_pkg::ST_EMPTY;
								rsp_word.list_empty = 1'b1;
							end else begin
								mem_cmd.rd = 1'b1;
							end
						end
						fsl_pkg::OP_RELEASE: begin
							rsp_word.load = 1'b1;
							if (slot_in_range) begin
								mem_cmd.wr          = 1'b1;
								rsp_word.status     = fsl_pkg::ST_DONE;
								rsp_word.list_empty = 1'b0;
							end else begin
								rsp_word.status     = fsl_pkg::ST_RANGE;
								rsp_word.list_empty = head_empty;
							end
						end
						fsl_pkg::OP_CLEAR: begin
						end
						default: begin
							rsp_word.load       = 1'b1;
							rsp_word.status     = fsl_pkg::ST_DONE;
							rsp_word.list_empty = head_empty;
						end
					endcase
				end
			end
			S_ALLOC: begin
				rsp_word.load         = 1'b1;
				rsp_word.status       = fsl_pkg::ST_DONE;
				rsp_word.granted_slot = granted_q;
				rsp_word.list_empty   = link_end;
			end
			S_SWEEP: begin
				mem_cmd.wr  = 1'b1;
				mem_wr_addr = sweep_cnt_q[IDX_W-1:0];
				mem_wr_data = (sweep_inc >= active_q) ? LINK_NULL : LINK_W'(sweep_inc);
				if (sweep_inc >= active_q) begin
					rsp_word.load   = sweep_rsp_q;
					rsp_word.status = fsl_pkg::ST_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer state, head pointer and pool size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			head_q      <= '0;
			active_q    <= ACTIVE_MAX;
			sweep_cnt_q <= '0;
			sweep_rsp_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd_word.opcode)
							fsl_pkg::OP_ALLOC: begin
								if (!head_empty) begin
									state_q <= S_ALLOC;
								end
							end
							fsl_pkg::OP_RELEASE: begin
								if (slot_in_range) begin
									head_q <= LINK_W'(cmd_word.release_slot);
								end
							end
							fsl_pkg::OP_CLEAR: begin
								active_q    <= active_clamped;
								sweep_cnt_q <= '0;
								sweep_rsp_q <= 1'b1;
								state_q     <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_ALLOC: begin
					head_q  <= link_end ? LINK_NULL : mem_rd_data;
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					sweep_cnt_q <= sweep_inc;
					if (sweep_inc >= active_q) begin
						head_q      <= '0;
						sweep_rsp_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// slot being handed out while its link is read
	always_ff @(posedge clk) begin
		if (mem_cmd.rd) begin
			granted_q <= fsl_pkg::SLOT_IDX_W'(head_q);
		end
	end

endmodule

// ===== design/fixed_slot_free_list.sv =====
// Fixed-slot free list: allocate pops the head slot, release pushes, clear relinks the pool.
// Release, empty allocate and unused opcodes are answered from the idle state; allocate goes
// through the alloc state, after the read of the head slot's link from the link memory.
// Clear sweeps N slots, one link memory write per slot, N the clamped slot count.
// One operation in flight: a new word is taken only when idle and the result register is free.
// After reset the block relinks the whole pool before taking words.
module fixed_slot_free_list #(
	parameter int SLOT_COUNT_MAX = fsl_pkg::SLOT_COUNT_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fsl_pkg::CFG_W-1:0] cfg_wdata,
	fsl_cmd_if.sink                   cmd,
	fsl_rsp_if.source                 rsp
);

	localparam int DEPTH  = (SLOT_COUNT_MAX < 256) ? SLOT_COUNT_MAX : 256;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int LINK_W = $clog2(SLOT_COUNT_MAX + 1);

	logic [fsl_pkg::CFG_W-1:0]      slots_q;
	logic                           rsp_valid_q;
	logic [1:0]                     rsp_status_q;
	logic [fsl_pkg::SLOT_IDX_W-1:0] rsp_granted_q;
	logic                           rsp_empty_q;

	fsl_pkg::cmd_t     cmd_word;
	fsl_pkg::rsp_t     rsp_word;
	fsl_pkg::mem_cmd_t mem_cmd;
	logic [IDX_W-1:0]  mem_wr_addr;
	logic [LINK_W-1:0] mem_wr_data;
	logic [IDX_W-1:0]  mem_rd_addr;
	logic [LINK_W-1:0] mem_rd_data;
	logic              rsp_free;

	// slot count register, used at the next clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= fsl_pkg::CFG_RESET;
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	assign cmd_word.opcode       = cmd.opcode;
	assign cmd_word.release_slot = cmd.release_slot;
	assign rsp_free              = !rsp_valid_q || rsp.ready;

	fsl_ctrl #(
		.SLOT_COUNT_MAX (SLOT_COUNT_MAX),
		.DEPTH          (DEPTH),
		.LINK_W         (LINK_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.slots_cfg   (slots_q),
		.cmd_valid   (cmd.valid),
		.cmd_ready   (cmd.ready),
		.cmd_word    (cmd_word),
		.rsp_free    (rsp_free),
		.rsp_word    (rsp_word),
		.mem_cmd     (mem_cmd),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	fsl_link_mem #(
		.DEPTH  (DEPTH),
		.LINK_W (LINK_W)
	) u_link_mem (
		.clk     (clk),
		.cmd     (mem_cmd),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output word register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_word.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (rsp_word.load) begin
			rsp_status_q  <= rsp_word.status;
			rsp_granted_q <= rsp_word.granted_slot;
			rsp_empty_q   <= rsp_word.list_empty;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.granted_slot = rsp_granted_q;
	assign rsp.list_empty   = rsp_empty_q;

endmodule
